/* sv/cldrw_pkg.sv */
package cldrw_pkg;

    localparam int T_W    = 20;
    localparam int DIST_W = 32;

    localparam logic signed [T_W-1:0] T_MAX = 20'sh7FFFF;
    localparam logic signed [T_W-1:0] T_MIN = 20'sh80000;
    localparam logic signed [T_W-1:0] T_ONE = 20'sh10000;
    localparam logic [T_W-1:0]        T_NEG_LIMIT = 20'h80000;

    // quadratic vs linear threshold on |A|
    localparam logic [10:0] QUAD_RATIO = 11'd2000;

    typedef struct packed {
        logic signed [39:0] a;
        logic signed [39:0] b;
        logic signed [32:0] c;
    } coef_t;

    typedef struct packed {
        coef_t [1:0]        cf;
        logic signed [21:0] bw;
        logic [1:0]         u1;
        logic [1:0]         u2;
        logic [DIST_W-1:0]  dist0;
        logic               tnear;
    } job_t;

    typedef struct packed {
        logic quad;
        logic hit;
    } ax_t;

    typedef struct packed {
        coef_t              cf;
        logic signed [21:0] bw;
        logic               elig;
        logic               neg;
        logic [DIST_W-1:0]  dist0;
        logic               tnear;
    } lane_t;

    typedef struct packed {
        logic [DIST_W-1:0]     distance;
        logic                  upd;
        logic                  wind;
        logic signed [T_W-1:0] t;
        logic [DIST_W-1:0]     dist0;
        logic                  tnear;
    } res_t;

    function automatic logic [32:0] mag33(logic signed [32:0] x);
        logic [32:0] r;
        r = x[32] ? 33'(-x) : 33'(x);
        return r;
    endfunction

    function automatic logic [39:0] mag40(logic signed [39:0] x);
        logic [39:0] r;
        r = x[39] ? 40'(-x) : 40'(x);
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] sat34(logic [33:0] x);
        logic [DIST_W-1:0] r;
        r = (x[33:32] != 2'b00) ? {DIST_W{1'b1}} : x[31:0];
        return r;
    endfunction

endpackage

/* sv/curve_l1_distance_and_ray_winding_unit.sv */
// Pipeline: 4 setup stages, 40-stage square root, 21-stage root divider, 4 evaluation
// stages, 33-stage distance divider, output register; bit-serial root and dividers are
// fully pipelined. Throughput: one request per cycle unless the output stalls.
// A one-entry skid register takes a request while the output waits.
// Reset (aresetn low, synchronous) clears all valid bits; no request is lost after it.
module curve_l1_distance_and_ray_winding_unit
    import cldrw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [31:0]       s_point_x,
    input  logic signed [31:0]       s_point_y,
    input  logic signed [31:0]       s_start_x,
    input  logic signed [31:0]       s_start_y,
    input  logic signed [31:0]       s_ctrl_x,
    input  logic signed [31:0]       s_ctrl_y,
    input  logic signed [31:0]       s_end_x,
    input  logic signed [31:0]       s_end_y,
    input  logic [15:0]              s_conic_weight,
    input  logic                     s_is_line,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DIST_W-1:0]        m_l1_distance,
    output logic signed [1:0]        m_winding_delta,
    output logic signed [T_W-1:0]    m_hit_time
);

    typedef struct packed {
        logic signed [1:0][31:0] p;
        logic signed [1:0][31:0] s;
        logic signed [1:0][31:0] c;
        logic signed [1:0][31:0] e;
        logic [15:0]             w;
        logic                    line;
    } item_t;

    typedef struct packed {
        job_t job;
        ax_t  ax;
    } sq0_t;

    logic ce;
    assign ce = !m_valid || m_ready;

    // skid register
    item_t port_item;
    item_t skid_reg;
    logic  skid_valid_reg;
    item_t src;
    logic  src_valid;

    assign port_item.p    = {s_point_y, s_point_x};
    assign port_item.s    = {s_start_y, s_start_x};
    assign port_item.c    = {s_ctrl_y, s_ctrl_x};
    assign port_item.e    = {s_end_y, s_end_x};
    assign port_item.w    = s_conic_weight;
    assign port_item.line = s_is_line;

    assign s_ready   = !skid_valid_reg;
    assign src       = skid_valid_reg ? skid_reg : port_item;
    assign src_valid = skid_valid_reg || s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (ce) begin
            skid_valid_reg <= 1'b0;
        end else if (s_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ce && s_valid && !skid_valid_reg) begin
            skid_reg <= port_item;
        end
    end

    // stage 1: translate to the sample point, weight the control point
    logic                      s1_vld_reg;
    logic signed [32:0]        s1_q1_reg [2];
    logic signed [32:0]        s1_q3_reg [2];
    logic signed [49:0]        s1_prod_reg [2];
    logic                      s1_line_reg;
    logic signed [21:0]        s1_bw_reg;

    logic signed [32:0]        q1_next [2];
    logic signed [32:0]        q3_next [2];
    logic signed [49:0]        prod_next [2];
    logic signed [32:0]        cd [2];
    logic signed [16:0]        wt_s;
    logic signed [21:0]        bw_next;

    assign wt_s    = $signed({1'b0, src.w});
    assign bw_next = src.line ? 22'sd0 : (22'sd4096 - 22'(wt_s)) <<< 4;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            q1_next[k]   = 33'($signed(src.s[k])) - 33'($signed(src.p[k]));
            q3_next[k]   = 33'($signed(src.e[k])) - 33'($signed(src.p[k]));
            cd[k]        = 33'($signed(src.c[k])) - 33'($signed(src.p[k]));
            prod_next[k] = cd[k] * wt_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (ce) begin
            s1_vld_reg <= src_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_q1_reg   <= q1_next;
            s1_q3_reg   <= q3_next;
            s1_prod_reg <= prod_next;
            s1_line_reg <= src.line;
            s1_bw_reg   <= bw_next;
        end
    end

    // stage 2: coefficients, root selection flags, end point distances
    job_t               job_next;
    logic signed [37:0] q2 [2];
    logic [DIST_W-1:0]  d0;
    logic [DIST_W-1:0]  d1;

    always_comb begin
        job_next = '0;
        for (int k = 0; k < 2; k++) begin
            if (s1_line_reg) begin
                q2[k] = 38'((34'(s1_q1_reg[k]) + 34'(s1_q3_reg[k])) >>> 1);
            end else begin
                q2[k] = 38'(s1_prod_reg[k] >>> 12);
            end
            job_next.cf[k].a = 40'(s1_q1_reg[k]) - (40'(q2[k]) <<< 1) + 40'(s1_q3_reg[k]);
            job_next.cf[k].b = 40'(s1_q1_reg[k]) - 40'(q2[k]);
            job_next.cf[k].c = s1_q1_reg[k];
            job_next.u1[k] = (s1_q3_reg[k] <= 0 && (s1_q1_reg[k] > 0 || q2[k] > 0))
                          || (s1_q1_reg[k] > 0 && q2[k] < 0);
            job_next.u2[k] = (s1_q1_reg[k] <= 0 && (q2[k] > 0 || s1_q3_reg[k] > 0))
                          || (s1_q3_reg[k] > 0 && q2[k] < 0);
        end
        d0 = sat34(34'(mag33(s1_q1_reg[0])) + 34'(mag33(s1_q1_reg[1])));
        d1 = sat34(34'(mag33(s1_q3_reg[0])) + 34'(mag33(s1_q3_reg[1])));
        job_next.bw    = s1_bw_reg;
        job_next.tnear = d0 < d1;
        job_next.dist0 = (d0 < d1) ? d0 : d1;
    end

    logic s2_vld_reg;
    job_t s2_job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (ce) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_job_reg <= job_next;
        end
    end

    // stage 3: branch choice and partial products of B*B and A*C
    logic               s3_vld_reg;
    job_t               s3_job_reg;
    logic [1:0]         s3_quad_reg;
    logic [1:0]         s3_acneg_reg;
    logic [1:0]         s3_bnz_reg;
    logic [1:0][39:0]   s3_bhh_reg;
    logic [1:0][39:0]   s3_bhl_reg;
    logic [1:0][39:0]   s3_bll_reg;
    logic [1:0][39:0]   s3_ahh_reg;
    logic [1:0][39:0]   s3_ahl_reg;
    logic [1:0][39:0]   s3_alh_reg;
    logic [1:0][39:0]   s3_all_reg;

    logic [39:0] amag [2];
    logic [39:0] bmag [2];
    logic [39:0] cmag [2];
    logic [1:0]  quad_next;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            amag[k] = mag40(s2_job_reg.cf[k].a);
            bmag[k] = mag40(s2_job_reg.cf[k].b);
            cmag[k] = 40'(mag33(s2_job_reg.cf[k].c));
            quad_next[k] = (51'(amag[k]) * 51'(QUAD_RATIO))
                         > 51'((bmag[k] > cmag[k]) ? bmag[k] : cmag[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (ce) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_job_reg  <= s2_job_reg;
            s3_quad_reg <= quad_next;
            for (int k = 0; k < 2; k++) begin
                s3_acneg_reg[k] <= (s2_job_reg.cf[k].a[39] != s2_job_reg.cf[k].c[32])
                                || (s2_job_reg.cf[k].c == 33'sd0);
                s3_bnz_reg[k] <= s2_job_reg.cf[k].b != 40'sd0;
                s3_bhh_reg[k] <= bmag[k][39:20] * bmag[k][39:20];
                s3_bhl_reg[k] <= bmag[k][39:20] * bmag[k][19:0];
                s3_bll_reg[k] <= bmag[k][19:0] * bmag[k][19:0];
                s3_ahh_reg[k] <= amag[k][39:20] * cmag[k][39:20];
                s3_ahl_reg[k] <= amag[k][39:20] * cmag[k][19:0];
                s3_alh_reg[k] <= amag[k][19:0] * cmag[k][39:20];
                s3_all_reg[k] <= amag[k][19:0] * cmag[k][19:0];
            end
        end
    end

    // stage 4: discriminant
    logic [79:0] b2 [2];
    logic [79:0] ac [2];
    logic [79:0] disc_next [2];
    ax_t         ax_next [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            b2[k] = (80'(s3_bhh_reg[k]) << 40) + (80'(s3_bhl_reg[k]) << 21)
                  + 80'(s3_bll_reg[k]);
            ac[k] = (80'(s3_ahh_reg[k]) << 40)
                  + ((80'(s3_ahl_reg[k]) + 80'(s3_alh_reg[k])) << 20)
                  + 80'(s3_all_reg[k]);
            disc_next[k]    = s3_acneg_reg[k] ? b2[k] + ac[k] : b2[k] - ac[k];
            ax_next[k].quad = s3_quad_reg[k];
            if (s3_quad_reg[k]) begin
                ax_next[k].hit = s3_acneg_reg[k] || (ac[k] <= b2[k]);
            end else begin
                ax_next[k].hit = s3_bnz_reg[k];
            end
        end
    end

    logic        s4_vld_reg;
    job_t        s4_job_reg;
    logic [79:0] s4_disc_reg [2];
    ax_t         s4_ax_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (ce) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_job_reg <= s3_job_reg;
            for (int k = 0; k < 2; k++) begin
                s4_disc_reg[k] <= disc_next[k];
                s4_ax_reg[k]   <= ax_next[k];
            end
        end
    end

    // square roots, one per axis
    sq0_t        sq0_in;
    sq0_t        sq0_out;
    ax_t         sq1_out;
    logic        sq_vld [2];
    logic [39:0] sq_root [2];
    job_t        jb;
    ax_t         axo [2];
    logic        sqv;

    assign sq0_in.job = s4_job_reg;
    assign sq0_in.ax  = s4_ax_reg[0];

    cldrw_sqrt #(
        .RAD_W  (80),
        .SIDE_W ($bits(sq0_t))
    ) u_sqrt_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s4_vld_reg),
        .in_rad    (s4_disc_reg[0]),
        .in_side   (sq0_in),
        .out_valid (sq_vld[0]),
        .out_root  (sq_root[0]),
        .out_side  (sq0_out)
    );

    cldrw_sqrt #(
        .RAD_W  (80),
        .SIDE_W ($bits(ax_t))
    ) u_sqrt_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s4_vld_reg),
        .in_rad    (s4_disc_reg[1]),
        .in_side   (s4_ax_reg[1]),
        .out_valid (sq_vld[1]),
        .out_root  (sq_root[1]),
        .out_side  (sq1_out)
    );

    assign jb     = sq0_out.job;
    assign axo[0] = sq0_out.ax;
    assign axo[1] = sq1_out;
    assign sqv    = sq_vld[0] && sq_vld[1];

    // four root lanes: x first root, x second root, y first root, y second root
    logic                  ev_vld [4];
    res_t                  ev_res [4];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        localparam int AX = l / 2;
        localparam int RT = l % 2;

        logic signed [41:0]    num_s;
        logic signed [41:0]    den_s;
        logic [41:0]           nabs;
        logic [40:0]           dabs;
        lane_t                 ln_in;
        lane_t                 ln_out;
        logic                  dv_vld;
        logic [T_W-1:0]        dv_quo;
        logic                  dv_ovf;
        logic signed [T_W-1:0] t_sat;

        always_comb begin
            if (axo[AX].quad) begin
                if (RT == 0) begin
                    num_s = 42'(jb.cf[AX].b) - $signed({2'b00, sq_root[AX]});
                end else begin
                    num_s = 42'(jb.cf[AX].b) + $signed({2'b00, sq_root[AX]});
                end
                den_s = 42'(jb.cf[AX].a);
            end else begin
                num_s = 42'(jb.cf[AX].c);
                den_s = 42'(jb.cf[AX].b) <<< 1;
            end
            nabs = num_s[41] ? 42'(-num_s) : 42'(num_s);
            dabs = 41'(den_s[41] ? -den_s : den_s);

            ln_in.cf    = jb.cf[1-AX];
            ln_in.bw    = jb.bw;
            ln_in.elig  = axo[AX].hit && ((RT == 0) ? jb.u1[AX] : jb.u2[AX]);
            ln_in.neg   = num_s[41] ^ den_s[41];
            ln_in.dist0 = jb.dist0;
            ln_in.tnear = jb.tnear;
        end

        cldrw_div #(
            .NUM_W  (58),
            .DEN_W  (41),
            .Q_W    (T_W),
            .SIDE_W ($bits(lane_t))
        ) u_root_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (sqv),
            .in_num    ({nabs, 16'b0}),
            .in_den    (dabs),
            .in_side   (ln_in),
            .out_valid (dv_vld),
            .out_quo   (dv_quo),
            .out_ovf   (dv_ovf),
            .out_side  (ln_out)
        );

        // truncated quotient with sign, clamped to the parameter range
        always_comb begin
            if (ln_out.neg) begin
                if (dv_ovf || dv_quo > T_NEG_LIMIT) begin
                    t_sat = T_MIN;
                end else begin
                    t_sat = -$signed(dv_quo);
                end
            end else begin
                if (dv_ovf || dv_quo[T_W-1]) begin
                    t_sat = T_MAX;
                end else begin
                    t_sat = $signed(dv_quo);
                end
            end
        end

        cldrw_eval u_eval (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (dv_vld),
            .in_t      (t_sat),
            .in_lane   (ln_out),
            .out_valid (ev_vld[l]),
            .out_res   (ev_res[l])
        );
    end

    // merge lanes in root order; a candidate wins only if strictly nearer
    logic [DIST_W-1:0]     fin_dist;
    logic signed [T_W-1:0] fin_time;
    logic signed [1:0]     fin_wind;
    logic                  fin_vld;

    always_comb begin
        fin_dist = ev_res[0].dist0;
        fin_time = ev_res[0].tnear ? '0 : T_ONE;
        for (int l = 0; l < 4; l++) begin
            if (ev_res[l].upd && ev_res[l].distance < fin_dist) begin
                fin_dist = ev_res[l].distance;
                fin_time = ev_res[l].t;
            end
        end
        case ({ev_res[0].wind, ev_res[1].wind})
            2'b10:   fin_wind = 2'sb01;
            2'b01:   fin_wind = 2'sb11;
            default: fin_wind = 2'sb00;
        endcase
        fin_vld = ev_vld[0] && ev_vld[1] && ev_vld[2] && ev_vld[3];
    end

    logic                  m_valid_reg;
    logic [DIST_W-1:0]     m_dist_reg;
    logic signed [1:0]     m_wind_reg;
    logic signed [T_W-1:0] m_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= fin_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_dist_reg <= fin_dist;
            m_wind_reg <= fin_wind;
            m_time_reg <= fin_time;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_l1_distance   = m_dist_reg;
    assign m_winding_delta = m_wind_reg;
    assign m_hit_time      = m_time_reg;

endmodule

/* sv/cldrw_sqrt.sv */
module cldrw_sqrt
    import cldrw_pkg::*;
#(
    parameter int RAD_W  = 80,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [RAD_W/2-1:0]    out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic                vld_reg  [ROOT_W];
    logic [RAD_W-1:0]    rad_reg  [ROOT_W];
    logic [REM_W-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [SIDE_W-1:0]   side_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stg
        logic              vld_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (i == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign vld_in  = vld_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // bring down the next pair of radicand bits and try root bit one
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
        assign trial  = {root_in, 2'b01};

        always_comb begin
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (ce) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rad_reg[i]  <= {rad_in[RAD_W-3:0], 2'b00};
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

/* sv/cldrw_div.sv */
module cldrw_div
    import cldrw_pkg::*;
#(
    parameter int NUM_W  = 58,
    parameter int DEN_W  = 41,
    parameter int Q_W    = 20,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quo,
    output logic              out_ovf,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              vld_reg  [Q_W+1];
    logic [NUM_W-1:0]  rem_reg  [Q_W+1];
    logic [DEN_W-1:0]  den_reg  [Q_W+1];
    logic [Q_W-1:0]    quo_reg  [Q_W+1];
    logic              ovf_reg  [Q_W+1];
    logic [SIDE_W-1:0] side_reg [Q_W+1];

    // entry stage: flag quotients that do not fit in Q_W bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= CMP_W'(in_num) >= (CMP_W'(in_den) << Q_W);
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stg
        localparam int BIT = Q_W - 1 - k;
        logic [CMP_W-1:0] dsh;
        logic [NUM_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        assign dsh = CMP_W'(den_reg[k]) << BIT;

        always_comb begin
            rem_next = rem_reg[k];
            quo_next = quo_reg[k];
            if (CMP_W'(rem_reg[k]) >= dsh) begin
                rem_next      = NUM_W'(CMP_W'(rem_reg[k]) - dsh);
                quo_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (ce) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= den_reg[k];
                quo_reg[k+1]  <= quo_next;
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_quo   = quo_reg[Q_W];
    assign out_ovf   = ovf_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule

/* sv/cldrw_eval.sv */
module cldrw_eval
    import cldrw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  logic signed [T_W-1:0] in_t,
    input  lane_t                 in_lane,
    output logic                  out_valid,
    output res_t                  out_res
);

    // stage 1: weight product and split A*t
    logic signed [22:0] bw2_in;
    logic signed [19:0] a_hi;
    logic signed [20:0] a_lo;

    logic                  e1_vld_reg;
    logic signed [42:0]    e1_w1_reg;
    logic signed [39:0]    e1_pah_reg;
    logic signed [40:0]    e1_pal_reg;
    logic signed [T_W-1:0] e1_t_reg;
    lane_t                 e1_lane_reg;

    assign bw2_in = $signed({in_lane.bw, 1'b0});
    assign a_hi   = $signed(in_lane.cf.a[39:20]);
    assign a_lo   = $signed({1'b0, in_lane.cf.a[19:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
        end else if (ce) begin
            e1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e1_w1_reg   <= bw2_in * in_t;
            e1_pah_reg  <= a_hi * in_t;
            e1_pal_reg  <= a_lo * in_t;
            e1_t_reg    <= in_t;
            e1_lane_reg <= in_lane;
        end
    end

    // stage 2: inner terms of both polynomials
    logic signed [22:0] bw2_e1;
    logic signed [59:0] at_full;
    logic signed [27:0] wt_next;
    logic signed [45:0] rt_next;

    logic                  e2_vld_reg;
    logic signed [27:0]    e2_wt_reg;
    logic signed [45:0]    e2_rt_reg;
    logic signed [T_W-1:0] e2_t_reg;
    lane_t                 e2_lane_reg;

    assign bw2_e1  = $signed({e1_lane_reg.bw, 1'b0});
    assign at_full = (60'(e1_pah_reg) <<< 20) + 60'(e1_pal_reg);
    assign wt_next = 28'(e1_w1_reg >>> 16) - 28'(bw2_e1);
    assign rt_next = 46'(at_full >>> 16) - (46'(e1_lane_reg.cf.b) <<< 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_vld_reg <= 1'b0;
        end else if (ce) begin
            e2_vld_reg <= e1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e2_wt_reg   <= wt_next;
            e2_rt_reg   <= rt_next;
            e2_t_reg    <= e1_t_reg;
            e2_lane_reg <= e1_lane_reg;
        end
    end

    // stage 3: outer products, r product split in halves
    logic signed [23:0] r_hi;
    logic signed [22:0] r_lo;

    logic                  e3_vld_reg;
    logic signed [47:0]    e3_mw_reg;
    logic signed [43:0]    e3_prh_reg;
    logic signed [42:0]    e3_prl_reg;
    logic signed [T_W-1:0] e3_t_reg;
    lane_t                 e3_lane_reg;

    assign r_hi = $signed(e2_rt_reg[45:22]);
    assign r_lo = $signed({1'b0, e2_rt_reg[21:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e3_vld_reg <= 1'b0;
        end else if (ce) begin
            e3_vld_reg <= e2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e3_mw_reg   <= e2_wt_reg * e2_t_reg;
            e3_prh_reg  <= r_hi * e2_t_reg;
            e3_prl_reg  <= r_lo * e2_t_reg;
            e3_t_reg    <= e2_t_reg;
            e3_lane_reg <= e2_lane_reg;
        end
    end

    // stage 4: finish weight and coordinate, take magnitude
    logic signed [32:0] wq;
    logic signed [65:0] rr;
    logic signed [50:0] r_val;
    logic [50:0]        r_mag;
    logic               w_pos;

    logic                  e4_vld_reg;
    logic [50:0]           e4_rmag_reg;
    logic [31:0]           e4_den_reg;
    logic                  e4_wpos_reg;
    logic                  e4_rpos_reg;
    logic signed [T_W-1:0] e4_t_reg;
    lane_t                 e4_lane_reg;

    assign wq    = 33'(e3_mw_reg >>> 16) + 33'sd65536;
    assign rr    = (66'(e3_prh_reg) <<< 22) + 66'(e3_prl_reg);
    assign r_val = 51'(rr >>> 16) + 51'(e3_lane_reg.cf.c);
    assign r_mag = r_val[50] ? 51'(-r_val) : 51'(r_val);
    assign w_pos = !wq[32] && (wq != 33'sd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e4_vld_reg <= 1'b0;
        end else if (ce) begin
            e4_vld_reg <= e3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e4_rmag_reg <= r_mag;
            e4_den_reg  <= w_pos ? wq[31:0] : 32'd1;
            e4_wpos_reg <= w_pos;
            e4_rpos_reg <= !r_val[50] && (r_val != 51'sd0);
            e4_t_reg    <= e3_t_reg;
            e4_lane_reg <= e3_lane_reg;
        end
    end

    // candidate distance |r| / wq
    res_t             dv_side_in;
    res_t             dv_side_out;
    logic [DIST_W-1:0] dv_quo;
    logic             dv_ovf;

    always_comb begin
        dv_side_in       = '0;
        dv_side_in.upd   = e4_lane_reg.elig && e4_wpos_reg;
        dv_side_in.wind  = e4_lane_reg.elig && e4_rpos_reg;
        dv_side_in.t     = e4_t_reg;
        dv_side_in.dist0 = e4_lane_reg.dist0;
        dv_side_in.tnear = e4_lane_reg.tnear;
    end

    cldrw_div #(
        .NUM_W  (67),
        .DEN_W  (32),
        .Q_W    (DIST_W),
        .SIDE_W ($bits(res_t))
    ) u_cand_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (e4_vld_reg),
        .in_num    ({e4_rmag_reg, 16'b0}),
        .in_den    (e4_den_reg),
        .in_side   (dv_side_in),
        .out_valid (out_valid),
        .out_quo   (dv_quo),
        .out_ovf   (dv_ovf),
        .out_side  (dv_side_out)
    );

    always_comb begin
        out_res          = dv_side_out;
        out_res.distance = dv_ovf ? {DIST_W{1'b1}} : dv_quo;
    end

endmodule
